// ===== rtl/crtd_pkg.sv =====
// ----------------------------------------------------------------------------
// crtd_pkg: shared types for the child route table
// Request token that travels along the cell chain, command codes and the
// sequencer states.
// ----------------------------------------------------------------------------
package crtd_pkg;

  localparam int unsigned ADDR_W  = 16;
  localparam int unsigned SEQ_W   = 8;
  localparam int unsigned TICKS_W = 16;
  localparam int unsigned OP_W    = 2;

  localparam logic [TICKS_W-1:0] TIMEOUT_RESET = TICKS_W'(60);

  // Commands carried by a token. The first four match the request opcodes.
  typedef enum logic [2:0] {
    CMD_OBSERVE = 3'd0,
    CMD_LOOKUP  = 3'd1,
    CMD_PURGE   = 3'd2,
    CMD_TICK    = 3'd3,
    CMD_INSERT  = 3'd4
  } cmd_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [ADDR_W-1:0] target;
    logic [ADDR_W-1:0] from;
    logic [SEQ_W-1:0]  seq;
    logic              found;
    logic [ADDR_W-1:0] hop;
    logic              dup;
    logic              claimed;
  } tok_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_WALK = 2'd1,
    ST_HOLD = 2'd2
  } state_t;

endpackage

// ===== rtl/crtd_cell.sv =====
// ----------------------------------------------------------------------------
// crtd_cell: one table slot in the chain
// Holds one entry, applies the passing token to it and hands the token to
// the next cell through its token register.
// ----------------------------------------------------------------------------
module crtd_cell
  import crtd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic [TICKS_W-1:0] fresh_ticks,
  input  logic               tok_vld_i,
  input  tok_t               tok_i,
  output logic               tok_vld_o,
  output tok_t               tok_o
);

  logic               valid_r;
  logic [ADDR_W-1:0]  dest_r;
  logic [ADDR_W-1:0]  hop_r;
  logic [SEQ_W-1:0]   seq_r;
  logic [TICKS_W-1:0] ticks_r;
  logic               tok_vld_r;
  tok_t               tok_r;
  tok_t               tok_nxt;
  logic               match;

  assign match = valid_r && (dest_r == tok_i.target);

  always_comb begin
    tok_nxt = tok_i;
    case (tok_i.cmd)
      CMD_OBSERVE: begin
        if (match) begin
          tok_nxt.found = 1'b1;
          tok_nxt.dup   = (seq_r == tok_i.seq);
        end
      end
      CMD_LOOKUP: begin
        if (match) begin
          tok_nxt.found = 1'b1;
          tok_nxt.hop   = hop_r;
        end
      end
      CMD_PURGE: begin
        if (match) begin
          tok_nxt.found = 1'b1;
        end
      end
      CMD_INSERT: begin
        if (!valid_r) begin
          tok_nxt.claimed = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Entry valid bit and token valid are control; the rest is payload.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      tok_vld_r <= 1'b0;
    end else begin
      tok_vld_r <= tok_vld_i;
      if (tok_vld_i) begin
        case (tok_i.cmd)
          CMD_PURGE: begin
            if (match) begin
              valid_r <= 1'b0;
            end
          end
          CMD_TICK: begin
            if (valid_r && (ticks_r <= TICKS_W'(1))) begin
              valid_r <= 1'b0;
            end
          end
          CMD_INSERT: begin
            if (!valid_r && !tok_i.claimed) begin
              valid_r <= 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    tok_r <= tok_nxt;
    if (tok_vld_i) begin
      case (tok_i.cmd)
        CMD_OBSERVE: begin
          if (match && (seq_r != tok_i.seq)) begin
            hop_r   <= tok_i.from;
            seq_r   <= tok_i.seq;
            ticks_r <= fresh_ticks;
          end
        end
        CMD_TICK: begin
          if (valid_r && (ticks_r > TICKS_W'(1))) begin
            ticks_r <= ticks_r - TICKS_W'(1);
          end
        end
        CMD_INSERT: begin
          if (!valid_r && !tok_i.claimed) begin
            dest_r  <= tok_i.target;
            hop_r   <= tok_i.from;
            seq_r   <= tok_i.seq;
            ticks_r <= fresh_ticks;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign tok_vld_o = tok_vld_r;
  assign tok_o     = tok_r;

endmodule

// ===== rtl/child_route_table_dedup.sv =====
// ----------------------------------------------------------------------------
// child_route_table_dedup: downstream route table with duplicate suppression
// A chain of slot cells; one request token walks the chain at a time.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : request channel (valid/ready). in_operation picks observe packet,
//           lookup next hop, purge destination or time tick.
//   out_* : one result per request (valid/ready), in request order.
//   cfg_* : write channel for timeout_ticks; always ready, write only when
//           the block is idle. A timeout of 0 acts as 1.
// Chain walk:
//   A request enters cell 0 at its accept edge, passes through every cell
//   in order and is captured off the chain tail; one token walks the chain
//   at a time, so the walk length sets the rate. An observe of an unknown
//   source walks the chain a second time to claim the lowest free slot.
//   The next request is taken once the result sits in the output register.
// Reset (rst_n low, synchronous): all entries invalid, timeout back to 60,
//   no request in flight, no result pending.
// Stall: while out_ready is low the result holds in the output register;
//   one more finished result may wait behind it, and in_ready stays low.
// ----------------------------------------------------------------------------
module child_route_table_dedup
  import crtd_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  // request channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [OP_W-1:0]    in_operation,
  input  logic [ADDR_W-1:0]  in_target_address,
  input  logic [ADDR_W-1:0]  in_from_address,
  input  logic [SEQ_W-1:0]   in_sequence_number,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_found,
  output logic [ADDR_W-1:0]  out_next_hop,
  output logic               out_duplicate,
  output logic               out_created,
  output logic               out_table_full,
  // configuration write
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [TICKS_W-1:0] cfg_timeout_ticks
);

  state_t             state_r, state_nxt;
  logic [TICKS_W-1:0] timeout_r;
  logic [TICKS_W-1:0] fresh_ticks;

  // chain wiring: stage 0 is the head input, stage MAX_ENTRIES the tail
  logic               chain_vld [0:MAX_ENTRIES];
  tok_t               chain_tok [0:MAX_ENTRIES];

  logic               reinject;
  logic               load_res;
  logic               load_out;
  tok_t               new_tok;
  tok_t               tail_tok;

  logic               res_found_r, res_dup_r, res_created_r, res_full_r;
  logic [ADDR_W-1:0]  res_hop_r;

  logic               out_valid_r;
  logic               out_found_r, out_dup_r, out_created_r, out_full_r;
  logic [ADDR_W-1:0]  out_hop_r;

  // Configuration register; a zero timeout behaves as one tick.
  assign cfg_ready   = 1'b1;
  assign fresh_ticks = (timeout_r == '0) ? TICKS_W'(1) : timeout_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      timeout_r <= cfg_timeout_ticks;
    end
  end

  // Build the head token: a fresh request, or the insert pass that follows
  // an observe which found no entry.
  assign tail_tok = chain_tok[MAX_ENTRIES];

  always_comb begin
    new_tok = '0;
    if (reinject) begin
      new_tok.cmd    = CMD_INSERT;
      new_tok.target = tail_tok.target;
      new_tok.from   = tail_tok.from;
      new_tok.seq    = tail_tok.seq;
    end else begin
      new_tok.cmd    = cmd_t'({1'b0, in_operation});
      new_tok.target = in_target_address;
      new_tok.from   = in_from_address;
      new_tok.seq    = in_sequence_number;
    end
  end

  assign chain_vld[0] = (in_valid && in_ready) || reinject;
  assign chain_tok[0] = new_tok;

  for (genvar gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
    crtd_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .fresh_ticks (fresh_ticks),
      .tok_vld_i   (chain_vld[gi]),
      .tok_i       (chain_tok[gi]),
      .tok_vld_o   (chain_vld[gi+1]),
      .tok_o       (chain_tok[gi+1])
    );
  end

  // Sequencer: idle, token on the chain, result waiting for the output slot.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    reinject  = 1'b0;
    load_res  = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (chain_vld[MAX_ENTRIES]) begin
          if ((tail_tok.cmd == CMD_OBSERVE) && !tail_tok.found) begin
            // unknown source: walk again to claim the lowest free slot
            reinject = 1'b1;
          end else begin
            load_res  = 1'b1;
            state_nxt = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Capture the finished result from the chain tail.
  always_ff @(posedge clk) begin
    if (load_res) begin
      res_found_r   <= (tail_tok.cmd != CMD_INSERT) && tail_tok.found;
      res_hop_r     <= tail_tok.hop;
      res_dup_r     <= tail_tok.dup;
      res_created_r <= (tail_tok.cmd == CMD_INSERT) && tail_tok.claimed;
      res_full_r    <= (tail_tok.cmd == CMD_INSERT) && !tail_tok.claimed;
    end
  end

  // Output register: holds while the receiver stalls.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_found_r   <= res_found_r;
      out_hop_r     <= res_hop_r;
      out_dup_r     <= res_dup_r;
      out_created_r <= res_created_r;
      out_full_r    <= res_full_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_found      = out_found_r;
  assign out_next_hop   = out_hop_r;
  assign out_duplicate  = out_dup_r;
  assign out_created    = out_created_r;
  assign out_table_full = out_full_r;

endmodule

// ===== tb/sv/child_route_table_dedup_tb.sv =====
// ----------------------------------------------------------------------------
// child_route_table_dedup_tb: self-checking bench for the child route table
// Sends observe, lookup, purge and tick requests with random idling on both
// channels. A behavioral copy of the table predicts every result, and each
// result field is checked in request order. Several timeout settings are
// written between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module child_route_table_dedup_tb;
  import crtd_pkg::*;

  localparam int unsigned SLOTS        = 16;
  localparam int unsigned POOL_SIZE    = 20;
  localparam int unsigned PHASES       = 6;
  localparam int unsigned PHASE_ITEMS  = 125;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 2 * SLOTS + 8;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned MAX_PRINTS   = 200;
  localparam int unsigned CLK_PERIOD   = 10;

  // Request opcodes, taken from the package command codes.
  localparam logic [OP_W-1:0] OP_OBSERVE = OP_W'(CMD_OBSERVE);
  localparam logic [OP_W-1:0] OP_LOOKUP  = OP_W'(CMD_LOOKUP);
  localparam logic [OP_W-1:0] OP_PURGE   = OP_W'(CMD_PURGE);
  localparam logic [OP_W-1:0] OP_TICK    = OP_W'(CMD_TICK);

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] next_hop;
    logic              duplicate;
    logic              created;
    logic              table_full;
  } route_outcome_t;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] target;
    logic [ADDR_W-1:0] from_addr;
    logic [SEQ_W-1:0]  seq;
    bit                typed;
    route_outcome_t    outcome;
  } route_request_t;

  // DUT ports; every input starts at a known value.
  logic               clk                = 1'b0;
  logic               rst_n              = 1'b0;
  logic               in_valid           = 1'b0;
  logic               in_ready;
  logic [OP_W-1:0]    in_operation       = '0;
  logic [ADDR_W-1:0]  in_target_address  = '0;
  logic [ADDR_W-1:0]  in_from_address    = '0;
  logic [SEQ_W-1:0]   in_sequence_number = '0;
  logic               out_valid;
  logic               out_ready          = 1'b0;
  logic               out_found;
  logic [ADDR_W-1:0]  out_next_hop;
  logic               out_duplicate;
  logic               out_created;
  logic               out_table_full;
  logic               cfg_valid          = 1'b0;
  logic               cfg_ready;
  logic [TICKS_W-1:0] cfg_timeout_ticks  = '0;

  // Predicted table contents and timeout register.
  logic               tbl_valid [SLOTS];
  logic [ADDR_W-1:0]  tbl_dest  [SLOTS];
  logic [ADDR_W-1:0]  tbl_hop   [SLOTS];
  logic [SEQ_W-1:0]   tbl_seq   [SLOTS];
  logic [TICKS_W-1:0] tbl_ticks [SLOTS];
  logic [TICKS_W-1:0] timeout_reg = TIMEOUT_RESET;

  route_outcome_t     route_outcome_q[$];
  logic [ADDR_W-1:0]  addr_pool[POOL_SIZE];

  // Request currently offered: typed rows carry their own expected outcome.
  bit                 drv_typed   = 1'b0;
  route_outcome_t     drv_outcome = '0;

  bit                 quiet_phase  = 1'b0;
  bit                 hold_request = 1'b0;
  int unsigned        hold_left    = 0;
  int unsigned        cycle_count  = 0;
  int unsigned        error_count  = 0;

  child_route_table_dedup #(
    .MAX_ENTRIES(SLOTS)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_target_address (in_target_address),
    .in_from_address   (in_from_address),
    .in_sequence_number(in_sequence_number),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_found         (out_found),
    .out_next_hop      (out_next_hop),
    .out_duplicate     (out_duplicate),
    .out_created       (out_created),
    .out_table_full    (out_table_full),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_timeout_ticks (cfg_timeout_ticks)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Return the lowest valid slot holding addr, or -1.
  function automatic int find_entry(logic [ADDR_W-1:0] addr);
    for (int i = 0; i < SLOTS; i++) begin
      if (tbl_valid[i] && tbl_dest[i] == addr) return i;
    end
    return -1;
  endfunction

  // Apply one request to the predicted table and return its outcome.
  function automatic route_outcome_t predict_route_outcome(
      logic [OP_W-1:0] op, logic [ADDR_W-1:0] target,
      logic [ADDR_W-1:0] from_addr, logic [SEQ_W-1:0] seq);
    route_outcome_t     res;
    int                 slot;
    logic [TICKS_W-1:0] fresh;
    res   = '0;
    // a programmed timeout of zero behaves as one tick
    fresh = (timeout_reg == '0) ? TICKS_W'(1) : timeout_reg;
    case (op)
      OP_OBSERVE: begin
        slot = find_entry(target);
        if (slot >= 0) begin
          res.found = 1'b1;
          if (tbl_seq[slot] == seq) begin
            // repeated sequence: leave entry and timer alone
            res.duplicate = 1'b1;
          end else begin
            tbl_hop[slot]   = from_addr;
            tbl_seq[slot]   = seq;
            tbl_ticks[slot] = fresh;
          end
        end else begin
          // scan downward so the lowest free slot wins
          for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!tbl_valid[i]) slot = i;
          end
          if (slot < 0) begin
            res.table_full = 1'b1;
          end else begin
            tbl_valid[slot] = 1'b1;
            tbl_dest[slot]  = target;
            tbl_hop[slot]   = from_addr;
            tbl_seq[slot]   = seq;
            tbl_ticks[slot] = fresh;
            res.created     = 1'b1;
          end
        end
      end
      OP_LOOKUP: begin
        slot = find_entry(target);
        if (slot >= 0) begin
          res.found    = 1'b1;
          res.next_hop = tbl_hop[slot];
        end
      end
      OP_PURGE: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (tbl_valid[i] && tbl_dest[i] == target) begin
            res.found    = 1'b1;
            tbl_valid[i] = 1'b0;
          end
        end
      end
      default: begin
        // tick: count down, drop entries that run out
        for (int i = 0; i < SLOTS; i++) begin
          if (tbl_valid[i]) begin
            if (tbl_ticks[i] <= TICKS_W'(1)) begin
              tbl_ticks[i] = '0;
              tbl_valid[i] = 1'b0;
            end else begin
              tbl_ticks[i] = tbl_ticks[i] - TICKS_W'(1);
            end
          end
        end
      end
    endcase
    return res;
  endfunction

  function automatic route_outcome_t make_outcome(logic found, logic [ADDR_W-1:0] hop,
      logic dup, logic created, logic full);
    route_outcome_t res;
    res.found      = found;
    res.next_hop   = hop;
    res.duplicate  = dup;
    res.created    = created;
    res.table_full = full;
    return res;
  endfunction

  function automatic route_request_t make_row(logic [OP_W-1:0] op,
      logic [ADDR_W-1:0] target, logic [ADDR_W-1:0] from_addr,
      logic [SEQ_W-1:0] seq, bit typed, route_outcome_t outcome);
    route_request_t req;
    req.op        = op;
    req.target    = target;
    req.from_addr = from_addr;
    req.seq       = seq;
    req.typed     = typed;
    req.outcome   = outcome;
    return req;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    error_count++;
    if (error_count <= MAX_PRINTS)
      $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
  endtask

  // --------------------------------------------------------------------------
  // Monitor: sample handshakes at the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    route_outcome_t want;
    route_outcome_t pred;
    cycle_count <= cycle_count + 1;
    if (!rst_n) begin
      // mirror the block's reset
      foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
      timeout_reg = TIMEOUT_RESET;
    end else begin
      // check the result leaving this edge against the oldest prediction
      if (out_valid && out_ready) begin
        if (route_outcome_q.size() == 0) begin
          report_mismatch("result with no request pending", 1, 0);
        end else begin
          want = route_outcome_q.pop_front();
          if (out_found !== want.found)
            report_mismatch("found", 32'(out_found), 32'(want.found));
          if (out_next_hop !== want.next_hop)
            report_mismatch("next_hop", 32'(out_next_hop), 32'(want.next_hop));
          if (out_duplicate !== want.duplicate)
            report_mismatch("duplicate", 32'(out_duplicate), 32'(want.duplicate));
          if (out_created !== want.created)
            report_mismatch("created", 32'(out_created), 32'(want.created));
          if (out_table_full !== want.table_full)
            report_mismatch("table_full", 32'(out_table_full), 32'(want.table_full));
        end
      end
      if (cfg_valid && cfg_ready) timeout_reg = cfg_timeout_ticks;
      // run the predictor on every accepted request to keep its table current
      if (in_valid && in_ready) begin
        pred = predict_route_outcome(in_operation, in_target_address,
                                     in_from_address, in_sequence_number);
        route_outcome_q.push_back(drv_typed ? drv_outcome : pred);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random back-pressure, plus one long hold on request
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left--;
    end else if (hold_request) begin
      // hold off long enough for the block to fill and stall its input
      hold_request = 1'b0;
      hold_left    = HOLD_CYCLES - 1;
      out_ready    = 1'b0;
    end else begin
      out_ready = quiet_phase || ($urandom_range(0, 99) >= 7);
    end
  end

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------

  // Offer one request at the falling edge and hold it until accepted.
  // Valid stays high afterwards; the caller drops it when the burst ends.
  task automatic send_request(route_request_t req);
    while (!quiet_phase && $urandom_range(0, 99) < 7) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid           = 1'b1;
    in_operation       = req.op;
    in_target_address  = req.target;
    in_from_address    = req.from_addr;
    in_sequence_number = req.seq;
    drv_typed          = req.typed;
    drv_outcome        = req.outcome;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    route_request_t     directed_rows[$];
    route_request_t     req;
    logic [TICKS_W-1:0] phase_timeout[PHASES];
    int                 pick;
    int                 slot;

    // Timeout per random phase: minimum, maximum, zero, short, short random, random.
    phase_timeout[0] = TICKS_W'(1);
    phase_timeout[1] = '1;
    phase_timeout[2] = '0;
    phase_timeout[3] = TICKS_W'(4);
    phase_timeout[4] = TICKS_W'($urandom_range(2, 12));
    phase_timeout[5] = TICKS_W'($urandom_range(1, 65535));

    // hold reset, then release it at a falling edge
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed requests, timeout at its reset value.
    // empty table: every request misses
    directed_rows.push_back(make_row(OP_LOOKUP, 16'h0000, 16'hFFFF, 8'hFF, 1'b1,
                                     make_outcome(1'b0, 16'h0000, 1'b0, 1'b0, 1'b0)));
    directed_rows.push_back(make_row(OP_TICK, 16'h5A5A, 16'hA5A5, 8'h5A, 1'b1,
                                     make_outcome(1'b0, 16'h0000, 1'b0, 1'b0, 1'b0)));
    directed_rows.push_back(make_row(OP_PURGE, 16'hFFFF, 16'h0000, 8'h00, 1'b1,
                                     make_outcome(1'b0, 16'h0000, 1'b0, 1'b0, 1'b0)));
    // create at the top address, then repeat its sequence number
    directed_rows.push_back(make_row(OP_OBSERVE, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1,
                                     make_outcome(1'b0, 16'h0000, 1'b0, 1'b1, 1'b0)));
    directed_rows.push_back(make_row(OP_OBSERVE, 16'hFFFF, 16'h1234, 8'hFF, 1'b1,
                                     make_outcome(1'b1, 16'h0000, 1'b1, 1'b0, 1'b0)));
    // duplicate must not have touched the next hop
    directed_rows.push_back(make_row(OP_LOOKUP, 16'hFFFF, 16'h0000, 8'h00, 1'b1,
                                     make_outcome(1'b1, 16'hFFFF, 1'b0, 1'b0, 1'b0)));
    // fresh sequence refreshes the hop
    directed_rows.push_back(make_row(OP_OBSERVE, 16'hFFFF, 16'h0000, 8'h00, 1'b1,
                                     make_outcome(1'b1, 16'h0000, 1'b0, 1'b0, 1'b0)));
    directed_rows.push_back(make_row(OP_LOOKUP, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1,
                                     make_outcome(1'b1, 16'h0000, 1'b0, 1'b0, 1'b0)));
    directed_rows.push_back(make_row(OP_OBSERVE, 16'h0000, 16'h8001, 8'h80, 1'b1,
                                     make_outcome(1'b0, 16'h0000, 1'b0, 1'b1, 1'b0)));
    // fill the remaining slots
    for (int a = 1; a <= SLOTS - 2; a++) begin
      directed_rows.push_back(make_row(OP_OBSERVE, ADDR_W'(a * 'h1111), ADDR_W'($urandom),
                                       SEQ_W'(a), 1'b0, '0));
    end
    // table full: new source dropped
    directed_rows.push_back(make_row(OP_OBSERVE, 16'hABCD, 16'h7FFE, 8'h01, 1'b1,
                                     make_outcome(1'b0, 16'h0000, 1'b0, 1'b0, 1'b1)));
    // tick always reports found as zero, even for a known key
    directed_rows.push_back(make_row(OP_TICK, 16'hFFFF, 16'hFFFF, 8'h00, 1'b1,
                                     make_outcome(1'b0, 16'h0000, 1'b0, 1'b0, 1'b0)));
    directed_rows.push_back(make_row(OP_PURGE, 16'h0000, 16'hFFFF, 8'hFF, 1'b1,
                                     make_outcome(1'b1, 16'h0000, 1'b0, 1'b0, 1'b0)));
    // freed slot is reused
    directed_rows.push_back(make_row(OP_OBSERVE, 16'hABCD, 16'h7FFE, 8'h01, 1'b0, '0));

    foreach (directed_rows[i]) send_request(directed_rows[i]);
    in_valid = 1'b0;

    // Random phases, one timeout setting each.
    for (int phase = 0; phase < PHASES; phase++) begin
      // drain before touching the register
      in_valid = 1'b0;
      while (route_outcome_q.size() != 0) @(negedge clk);
      cfg_valid         = 1'b1;
      cfg_timeout_ticks = phase_timeout[phase];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      @(negedge clk);
      cfg_valid = 1'b0;

      // one phase runs with no idling on either side
      quiet_phase = (phase == 2);
      // a small address pool keeps hits, fills and purges frequent
      foreach (addr_pool[i]) addr_pool[i] = ADDR_W'($urandom);
      addr_pool[0] = '0;
      addr_pool[1] = '1;

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 3 && n == 20) hold_request = 1'b1;
        if (phase == 4 && n == 60) begin
          // pause the sender until everything has come back
          in_valid = 1'b0;
          while (route_outcome_q.size() != 0) @(negedge clk);
        end
        pick   = $urandom_range(0, 99);
        req.op = (pick < 45) ? OP_OBSERVE :
                 (pick < 70) ? OP_LOOKUP  :
                 (pick < 80) ? OP_PURGE   : OP_TICK;
        req.target = ($urandom_range(0, 9) == 0) ? ADDR_W'($urandom) :
                     addr_pool[$urandom_range(0, POOL_SIZE - 1)];
        req.from_addr = ADDR_W'($urandom);
        req.seq       = SEQ_W'($urandom);
        // reuse the stored sequence often enough to hit duplicates
        slot = find_entry(req.target);
        if (slot >= 0 && $urandom_range(0, 99) < 40) req.seq = tbl_seq[slot];
        req.typed   = 1'b0;
        req.outcome = '0;
        send_request(req);
      end
    end

    in_valid    = 1'b0;
    quiet_phase = 1'b0;
    while (route_outcome_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/crtd_pkg.sv
rtl/crtd_cell.sv
rtl/child_route_table_dedup.sv
tb/sv/child_route_table_dedup_tb.sv
